>>> hdl/md5_message_digest_unit_macros.svh
// assertion macros for the md5 digest unit
`ifndef MD5_MESSAGE_DIGEST_UNIT_MACROS_SVH
`define MD5_MESSAGE_DIGEST_UNIT_MACROS_SVH

`define MD5_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define MD5_ASSERT_NODIS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/md5_pkg.sv
`default_nettype none
package md5_pkg;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam logic [7:0]  PAD_MARK = 8'h80;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_low;
      logic [63:0] digest_high;
   } rsp_type;

   // byte-level write and control command from controller to datapath
   typedef struct packed {
      logic       put;        // write one byte and advance the fill
      logic [7:0] byte_val;
      logic       start;      // start a compression
      logic       restart;    // reload initial chaining values, clear length and fill
      logic       add_len;    // add eight times count to bit length
      logic [2:0] len_count;
   } dp_cmd_type;

   typedef struct packed {
      logic       busy;       // compression in progress
      logic       done;       // compression finished this cycle
      logic [5:0] fill;
   } dp_status_type;

   localparam logic [31:0] SINE_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] SHIFT_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

endpackage
`default_nettype wire

>>> hdl/md5_if.sv
`default_nettype none
interface md5_req_if;
   import md5_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface md5_rsp_if;
   import md5_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/md5_message_digest_unit.sv
// md5 message digest unit
// req channel: one word per handshake, up to four little-endian bytes with a
// byte count and a last flag. rsp channel: the 128-bit digest as two 64-bit
// halves, one result per message, given after the word marked last.
// a word is packed byte by byte, and the next word is taken only after
// it; each time a 64-byte block fills, packing waits while the 64-round
// compression runs one round a cycle in a single round unit. the last word
// adds padding, one byte a cycle, up to two compressions, and a load of the
// result register.
// reset (synchronous) loads the initial chaining values, clears the length
// and fill and drops any pending result.
// a stalled rsp holds its digest; the unit keeps taking words of the next
// message meanwhile and only waits when a second digest is ready.
`default_nettype none
module md5_message_digest_unit (
   input  wire logic clock,
   input  wire logic reset,
   md5_req_if.sink   req,
   md5_rsp_if.source rsp
);
   import md5_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [63:0]   bit_len;
   rsp_type       digest;

   md5_control u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .cmd(cmd), .status(status), .bit_len(bit_len), .digest(digest)
   );

   md5_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .bit_len(bit_len), .digest(digest)
   );
endmodule
`default_nettype wire

>>> hdl/md5_datapath.sv
`default_nettype none
module md5_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire md5_pkg::dp_cmd_type    cmd,
   output md5_pkg::dp_status_type      status,
   output logic [63:0]                 bit_len,
   output md5_pkg::rsp_type            digest
);
   import md5_pkg::*;

   logic [31:0] buf_ff [16];
   logic [31:0] cv_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [63:0] len_ff;
   logic [5:0]  fill_ff;
   logic [5:0]  round_ff;
   logic        busy_ff, done_ff;
   logic [1:0]  phase;
   logic [3:0]  g;
   logic [31:0] f, sum, rot;
   logic [4:0]  s;

   always_comb begin
      phase = round_ff[5:4];
      case (phase)
         2'd0: begin
            f = (b_ff & c_ff) | (~b_ff & d_ff);
            g = round_ff[3:0];
         end
         2'd1: begin
            f = (d_ff & b_ff) | (~d_ff & c_ff);
            g = 4'(5 * round_ff[3:0] + 1);
         end
         2'd2: begin
            f = b_ff ^ c_ff ^ d_ff;
            g = 4'(3 * round_ff[3:0] + 5);
         end
         default: begin
            f = c_ff ^ (b_ff | ~d_ff);
            g = 4'(7 * round_ff[3:0]);
         end
      endcase
      s = SHIFT_TABLE[{phase, round_ff[1:0]}];
      sum = a_ff + f + SINE_TABLE[round_ff] + buf_ff[g];
      rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
      a_in = d_ff;
      b_in = b_ff + rot;
      c_in = b_ff;
      d_in = c_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         buf_ff[fill_ff[5:2]][8*fill_ff[1:0] +: 8] <= cmd.byte_val;
      end
      if (cmd.start) begin
         a_ff <= cv_ff[0];
         b_ff <= cv_ff[1];
         c_ff <= cv_ff[2];
         d_ff <= cv_ff[3];
      end else if (busy_ff) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         cv_ff[0] <= IV_A;
         cv_ff[1] <= IV_B;
         cv_ff[2] <= IV_C;
         cv_ff[3] <= IV_D;
         len_ff   <= '0;
         fill_ff  <= '0;
      end else begin
         if (cmd.put) fill_ff <= fill_ff + 6'd1;
         if (cmd.add_len) len_ff <= len_ff + {58'd0, cmd.len_count, 3'd0};
         if (busy_ff && round_ff == 6'd63) begin
            cv_ff[0] <= cv_ff[0] + a_in;
            cv_ff[1] <= cv_ff[1] + b_in;
            cv_ff[2] <= cv_ff[2] + c_in;
            cv_ff[3] <= cv_ff[3] + d_in;
         end
      end
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         done_ff <= busy_ff && round_ff == 6'd63;
         if (cmd.start) begin
            busy_ff  <= 1'b1;
            round_ff <= '0;
         end else if (busy_ff) begin
            round_ff <= round_ff + 6'd1;
            if (round_ff == 6'd63) busy_ff <= 1'b0;
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.fill = fill_ff;
   assign bit_len = len_ff;
   assign digest.digest_low  = {cv_ff[1], cv_ff[0]};
   assign digest.digest_high = {cv_ff[3], cv_ff[2]};
endmodule
`default_nettype wire

>>> hdl/md5_control.sv
`default_nettype none
`include "md5_message_digest_unit_macros.svh"
module md5_control (
   input  wire logic                   clock,
   input  wire logic                   reset,
   md5_req_if.sink                     req,
   md5_rsp_if.source                   rsp,
   output md5_pkg::dp_cmd_type         cmd,
   input  wire md5_pkg::dp_status_type status,
   input  wire logic [63:0]            bit_len,
   input  wire md5_pkg::rsp_type       digest
);
   import md5_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_BYTES = 7'b0000010,
      S_PAD   = 7'b0000100,
      S_ZERO  = 7'b0001000,
      S_LEN   = 7'b0010000,
      S_COMP  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in, ret_ff, ret_in;
   logic [31:0] data_ff, data_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [2:0]  idx_ff, idx_in;
   logic        last_ff, last_in;
   logic [63:0] len_ff, len_in;
   logic        rv_ff, rv_in;
   rsp_type     rd_ff, rd_in;
   logic [2:0]  clamp;

   assign clamp = (req.payload.byte_count > 3'd4) ? 3'd4 : req.payload.byte_count;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      data_in  = data_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      len_in   = len_ff;
      rv_in    = rv_ff;
      rd_in    = rd_ff;
      cmd      = '0;
      req.ready = (state_ff == S_IDLE);
      if (rsp.ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               data_in   = req.payload.data_word;
               cnt_in    = clamp;
               last_in   = req.payload.last;
               idx_in    = '0;
               cmd.add_len   = 1'b1;
               cmd.len_count = clamp;
               state_in  = S_BYTES;
            end
         end
         S_BYTES: begin
            if (idx_ff == cnt_ff) begin
               if (last_ff) begin
                  len_in   = bit_len;
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.put      = 1'b1;
               cmd.byte_val = data_ff[8*idx_ff[1:0] +: 8];
               idx_in       = idx_ff + 3'd1;
               if (status.fill == 6'd63) begin
                  cmd.start = 1'b1;
                  ret_in    = S_BYTES;
                  state_in  = S_COMP;
               end
            end
         end
         S_PAD: begin
            cmd.put      = 1'b1;
            cmd.byte_val = PAD_MARK;
            ret_in       = S_ZERO;
            state_in     = S_ZERO;
            if (status.fill == 6'd63) begin
               cmd.start = 1'b1;
               state_in  = S_COMP;
            end
         end
         S_ZERO: begin
            if (status.fill == 6'd56) begin
               idx_in   = '0;
               state_in = S_LEN;
            end else begin
               cmd.put = 1'b1;
               if (status.fill == 6'd63) begin
                  cmd.start = 1'b1;
                  ret_in    = S_ZERO;
                  state_in  = S_COMP;
               end
            end
         end
         S_LEN: begin
            cmd.put      = 1'b1;
            cmd.byte_val = len_ff[8*idx_ff +: 8];
            idx_in       = idx_ff + 3'd1;
            if (status.fill == 6'd63) begin
               cmd.start = 1'b1;
               ret_in    = S_OUT;
               state_in  = S_COMP;
            end
         end
         S_COMP: begin
            if (status.done) state_in = ret_ff;
         end
         S_OUT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in       = 1'b1;
               rd_in       = digest;
               cmd.restart = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         rv_ff    <= rv_in;
      end
      data_ff <= data_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
      len_ff  <= len_in;
      rd_ff   <= rd_in;
   end

   assign rsp.valid   = rv_ff;
   assign rsp.payload = rd_ff;

   `MD5_ASSERT(a_start_full, clock, reset, cmd.start |-> status.fill == 6'd63 && cmd.put, "compression started on a partial block")
   `MD5_ASSERT(a_comp_busy, clock, reset, state_ff == S_COMP && !status.done |-> status.busy || $past(cmd.start), "waiting on an idle datapath")
   `MD5_ASSERT(a_no_put_busy, clock, reset, status.busy |-> !cmd.put, "byte written during compression")
   `MD5_ASSERT(a_ready_idle, clock, reset, req.ready |-> !status.busy, "accepting while compressing")
endmodule
`default_nettype wire

>>> verif/md5_message_digest_unit_checker.sv
`default_nettype none
module md5_message_digest_unit_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  md5_pkg::req_type req_word,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  md5_pkg::rsp_type rsp_word,
   output int        fail_count,
   output int        pending_digests,
   output int        digests_seen
);
   import md5_pkg::*;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };
   localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                   6, 10, 15, 21};

   logic [31:0] chain [4];
   logic [31:0] block_words [16];
   logic [63:0] msg_bits;
   logic [5:0]  fill_pos;
   rsp_type     digest_queue [$];

   function automatic logic [31:0] rotl(logic [31:0] v, int s);
      return (s == 0) ? v : ((v << s) | (v >> (32 - s)));
   endfunction

   task automatic compress();
      logic [31:0] a, b, c, d, f, sum, t;
      int g;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int i = 0; i < 64; i++) begin
         case (i >> 4)
            0: begin f = (b & c) | (~b & d); g = i; end
            1: begin f = (d & b) | (~d & c); g = (5 * i + 1) & 15; end
            2: begin f = b ^ c ^ d; g = (3 * i + 5) & 15; end
            default: begin f = c ^ (b | ~d); g = (7 * i) & 15; end
         endcase
         sum = a + f + ROUND_CONST[i] + block_words[g];
         t = d; d = c; c = b;
         b = b + rotl(sum, ROT_AMT[((i >> 4) << 2) | (i & 3)]);
         a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
   endtask

   task automatic append_byte(logic [7:0] bv);
      int w, sh;
      w = fill_pos >> 2;
      sh = (fill_pos & 3) * 8;
      if (sh == 0) block_words[w] = 32'h0;
      block_words[w] = (block_words[w] & ~(32'hff << sh)) | (32'(bv) << sh);
      if (fill_pos == 6'd63) begin
         compress();
         fill_pos = 0;
      end else begin
         fill_pos = fill_pos + 1;
      end
   endtask

   task automatic restart_digest();
      chain[0] = IV_A; chain[1] = IV_B; chain[2] = IV_C; chain[3] = IV_D;
      msg_bits = 0;
      fill_pos = 0;
   endtask

   task automatic absorb_word(req_type w);
      int n;
      logic [63:0] len;
      rsp_type r;
      n = (w.byte_count > 4) ? 4 : int'(w.byte_count);
      for (int k = 0; k < n; k++) append_byte(w.data_word[8 * k +: 8]);
      msg_bits += 64'(n * 8);
      if (w.last) begin
         len = msg_bits;
         append_byte(PAD_MARK);
         while (fill_pos != 6'd56) append_byte(8'h00);
         for (int k = 0; k < 8; k++) append_byte(len[8 * k +: 8]);
         r.digest_low = {chain[1], chain[0]};
         r.digest_high = {chain[3], chain[2]};
         digest_queue.push_back(r);
         restart_digest();
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_d;
      if (reset) begin
         fail_count = 0;
         digests_seen = 0;
         digest_queue.delete();
         restart_digest();
      end else begin
         if (req_valid && req_ready) absorb_word(req_word);
         if (rsp_valid && rsp_ready) begin
            digests_seen++;
            if (digest_queue.size() == 0) begin
               $error("unexpected digest %h", rsp_word);
               fail_count++;
            end else begin
               exp_d = digest_queue.pop_front();
               if (rsp_word.digest_low !== exp_d.digest_low) begin
                  $error("digest_low expected %h actual %h", exp_d.digest_low,
                         rsp_word.digest_low);
                  fail_count++;
               end
               if (rsp_word.digest_high !== exp_d.digest_high) begin
                  $error("digest_high expected %h actual %h", exp_d.digest_high,
                         rsp_word.digest_high);
                  fail_count++;
               end
            end
         end
      end
      pending_digests = digest_queue.size();
   end
endmodule
`default_nettype wire

>>> verif/md5_message_digest_unit_tb.sv
`default_nettype none
module md5_message_digest_unit_tb;
   import md5_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   md5_req_if req_ch ();
   md5_rsp_if rsp_ch ();

   int fail_count, pending_digests, digests_seen;
   int idle_cycles = 0;
   int words_sent = 0;
   bit stim_done = 0;
   bit calm_phase = 0;
   bit hold_off = 0;
   req_type word_queue [$];

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   md5_message_digest_unit DUT (.clock(clock), .reset(reset), .req(req_ch.sink),
                                .rsp(rsp_ch.source));

   md5_message_digest_unit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_word(req_ch.payload),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_word(rsp_ch.payload),
      .fail_count(fail_count), .pending_digests(pending_digests),
      .digests_seen(digests_seen));

   function automatic req_type make_word(logic [31:0] d, logic [2:0] n, logic l);
      req_type w;
      w.data_word = d; w.byte_count = n; w.last = l;
      return w;
   endfunction

   task automatic add_message(int nwords, bit odd_tail);
      for (int i = 0; i < nwords; i++)
         word_queue.push_back(make_word($urandom, 3'd4, 1'b0));
      word_queue.push_back(make_word($urandom, odd_tail ? 3'($urandom_range(0, 3)) : 3'd4,
                                     1'b1));
   endtask

   task automatic build_stimulus();
      int r;
      // directed
      word_queue.push_back(make_word(32'h0, 3'd0, 1'b1));
      word_queue.push_back(make_word(32'h00636261, 3'd3, 1'b1));
      word_queue.push_back(make_word(32'hffffffff, 3'd4, 1'b0));
      word_queue.push_back(make_word(32'h0, 3'd0, 1'b0));
      word_queue.push_back(make_word(32'h12345678, 3'd7, 1'b0));
      word_queue.push_back(make_word(32'habcdef01, 3'd1, 1'b0));
      word_queue.push_back(make_word(32'h55aa55aa, 3'd5, 1'b0));
      word_queue.push_back(make_word(32'h00000000, 3'd6, 1'b1));
      for (int i = 0; i < 13; i++)
         word_queue.push_back(make_word(32'h01020304 * i, 3'd4, 1'b0));
      word_queue.push_back(make_word(32'hdeadbeef, 3'd2, 1'b1));
      // random: mostly well-formed messages, some odd counts mixed in
      while (word_queue.size() < 850) begin
         r = $urandom_range(0, 9);
         if (r < 6) add_message($urandom_range(0, 20), $urandom_range(0, 1) == 1);
         else if (r < 8) add_message($urandom_range(12, 34), 1'b1);
         else begin
            for (int i = 0; i < $urandom_range(1, 8); i++)
               word_queue.push_back(make_word($urandom, 3'($urandom_range(0, 7)),
                                              1'($urandom_range(0, 5) == 0)));
         end
      end
      word_queue.push_back(make_word($urandom, 3'd4, 1'b1));
   endtask

   initial begin
      build_stimulus();
      repeat (8) @(posedge clock);
      reset <= 0;
   end

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
         req_ch.payload <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            void'(word_queue.pop_front());
            words_sent++;
         end
         if (word_queue.size() == 0) begin
            req_ch.valid <= 0;
            stim_done <= 1;
         end else if (!req_ch.valid || req_ch.ready) begin
            if (calm_phase || $urandom_range(0, 99) >= 32) begin
               req_ch.valid <= 1;
               req_ch.payload <= word_queue[0];
            end else begin
               req_ch.valid <= 0;
            end
         end
      end
   end

   // receiver with one long hold-off
   initial begin
      wait (words_sent > 300);
      @(posedge clock);
      hold_off = 1;
      repeat (600) @(posedge clock);
      hold_off = 0;
      wait (words_sent > 500);
      calm_phase = 1;
      wait (words_sent > 650);
      calm_phase = 0;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 0;
      else
         rsp_ch.ready <= !hold_off && (calm_phase || $urandom_range(0, 99) >= 32);
   end

   // watchdog and verdict
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || hold_off)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d digests outstanding", pending_digests);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      wait (stim_done);
      wait (pending_digests == 0);
      repeat (400) @(posedge clock);
      $display("sent %0d words, checked %0d digests, including a long output stall",
               words_sent, digests_seen);
      if (fail_count == 0 && pending_digests == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/md5_pkg.sv
hdl/md5_if.sv
hdl/md5_datapath.sv
hdl/md5_control.sv
hdl/md5_message_digest_unit.sv
verif/md5_message_digest_unit_checker.sv
verif/md5_message_digest_unit_tb.sv
